/* sv/mss_pkg.sv */
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants of the motor start-up sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int LINE_BUFFER      = 64;
    localparam int TICK_COUNT_WIDTH = 16;
    localparam int POS_W            = $clog2(LINE_BUFFER);

    localparam int PCT_W    = 7;
    localparam int HOLD_W   = 16;
    localparam int PERIOD_W = 16;
    localparam int CMP_W    = 16;
    localparam int LED_W    = 11;
    localparam int HOLD_CMP_W = 33;

    // compare = floor(applied * period / 100) via reciprocal multiply
    localparam int PROD_W     = PCT_W + PERIOD_W;
    localparam int DIV_SHIFT  = 30;
    localparam int RECIP_W    = 24;
    localparam int RECIP_MUL_W = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << DIV_SHIFT) + 99) / 100);

    localparam logic [PCT_W-1:0] PCT_LIMIT = 7'd100;
    localparam logic [PCT_W-1:0] SPEED_LO  = 7'd30;
    localparam logic [PCT_W-1:0] SPEED_HI  = 7'd99;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_M_UP   = 8'h4D;
    localparam logic [7:0] CH_M_LO   = 8'h6D;
    localparam logic [7:0] CH_S_UP   = 8'h53;
    localparam logic [7:0] CH_S_LO   = 8'h73;

    localparam logic [LED_W-1:0] LED_OFF  = 11'd2000;
    localparam logic [LED_W-1:0] LED_IDLE = 11'd500;
    localparam logic [LED_W-1:0] LED_RUN  = 11'd10;

    localparam logic [2:0] CFG_OFF_DUTY     = 3'd0;
    localparam logic [2:0] CFG_IDLE_DUTY    = 3'd1;
    localparam logic [2:0] CFG_MIN_DUTY     = 3'd2;
    localparam logic [2:0] CFG_MAX_DUTY     = 3'd3;
    localparam logic [2:0] CFG_IDLE_HOLD    = 3'd4;
    localparam logic [2:0] CFG_STARTUP_HOLD = 3'd5;
    localparam logic [2:0] CFG_PWM_PERIOD   = 3'd6;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_BUTTON = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    typedef enum logic [1:0] {
        ST_OFF  = 2'd0,
        ST_IDLE = 2'd1,
        ST_RUN  = 2'd2
    } run_state_t;

    typedef struct packed {
        logic [PCT_W-1:0]    off_duty;
        logic [PCT_W-1:0]    idle_duty;
        logic [PCT_W-1:0]    min_duty;
        logic [PCT_W-1:0]    max_duty;
        logic [HOLD_W-1:0]   idle_hold;
        logic [HOLD_W-1:0]   startup_hold;
        logic [PERIOD_W-1:0] pwm_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        off_duty:     7'd2,
        idle_duty:    7'd28,
        min_duty:     7'd32,
        max_duty:     7'd95,
        idle_hold:    16'd5,
        startup_hold: 16'd10,
        pwm_period:   16'd40000
    };

    typedef struct packed {
        run_state_t                  run;
        run_state_t                  mode;
        logic [PCT_W-1:0]            target;
        logic [PCT_W-1:0]            applied;
        logic [TICK_COUNT_WIDTH-1:0] elapsed;
        logic [POS_W-1:0]            pos;
        logic [2:0][7:0]             chars;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        run:     ST_OFF,
        mode:    ST_OFF,
        target:  7'd2,
        applied: 7'd2,
        elapsed: '0,
        pos:     POS_W'(1),
        chars:   '0
    };

endpackage

/* sv/mss_step.sv */
// ----------------------------------------------------------------------------
// mss_step
// Next-state logic for one word: command line, button, tick, then one
// transition evaluation.
// ----------------------------------------------------------------------------
module mss_step
    import mss_pkg::*;
(
    input  seq_state_t  cur,
    input  cfg_t        cfg,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    output seq_state_t  nxt
);

    seq_state_t         pre;
    logic               dig1;
    logic               dig2;
    logic [3:0]         d1;
    logic [3:0]         d2;
    logic [PCT_W-1:0]   value;
    logic               value_ok;
    logic [PCT_W-1:0]   pct;
    logic               do_drive;
    logic [PCT_W-1:0]   clamped;
    logic [HOLD_CMP_W-1:0] elapsed_ext;

    assign dig1 = (cur.chars[1] >= CH_ZERO) && (cur.chars[1] < CH_COLON);
    assign dig2 = (cur.chars[2] >= CH_ZERO) && (cur.chars[2] < CH_COLON);
    assign d1   = 4'(cur.chars[1] - CH_ZERO);
    assign d2   = 4'(cur.chars[2] - CH_ZERO);

    always_comb
    begin
        value    = '0;
        value_ok = 1'b0;
        if (cur.pos == POS_W'(3) && dig1)
        begin
            value    = PCT_W'(d1);
            value_ok = 1'b1;
        end
        else if (cur.pos == POS_W'(4) && dig1 && dig2)
        begin
            value    = PCT_W'({d1, 3'b000}) + PCT_W'({d1, 1'b0}) + PCT_W'(d2);
            value_ok = 1'b1;
        end
    end

    // pre-evaluation update
    always_comb
    begin
        pre = cur;
        unique case (req_type)
            REQ_BYTE:
            begin
                if (cur.pos >= POS_W'(1) && cur.pos <= POS_W'(3))
                begin
                    pre.chars[2'(cur.pos - POS_W'(1))] = rx_byte;
                end
                if (rx_byte == CH_CR)
                begin
                    if (value_ok)
                    begin
                        if (cur.chars[0] == CH_M_UP || cur.chars[0] == CH_M_LO)
                        begin
                            if (value <= PCT_W'(2))
                            begin
                                pre.mode = run_state_t'(value[1:0]);
                            end
                        end
                        else if (cur.chars[0] == CH_S_UP || cur.chars[0] == CH_S_LO)
                        begin
                            if (value >= SPEED_LO && value <= SPEED_HI)
                            begin
                                pre.target = value;
                            end
                        end
                    end
                    pre.chars = '0;
                    pre.pos   = POS_W'(1);
                end
                else if (cur.pos >= POS_W'(LINE_BUFFER - 1))
                begin
                    pre.pos = POS_W'(1);
                end
                else
                begin
                    pre.pos = cur.pos + POS_W'(1);
                end
            end
            REQ_BUTTON:
            begin
                pre.mode = (cur.run == ST_OFF) ? ST_IDLE : ST_OFF;
            end
            REQ_TICK:
            begin
                if (cur.elapsed != '1)
                begin
                    pre.elapsed = cur.elapsed + TICK_COUNT_WIDTH'(1);
                end
            end
            default:
            begin
                pre = cur;
            end
        endcase
    end

    assign elapsed_ext = HOLD_CMP_W'(pre.elapsed);

    always_comb
    begin
        clamped = pre.target;
        if (clamped < cfg.min_duty)
        begin
            clamped = cfg.min_duty;
        end
        if (clamped > cfg.max_duty)
        begin
            clamped = cfg.max_duty;
        end
    end

    // transition evaluation
    always_comb
    begin
        nxt      = pre;
        pct      = '0;
        do_drive = 1'b0;
        unique case (pre.run)
            ST_OFF:
            begin
                if (pre.mode == ST_IDLE)
                begin
                    pct         = cfg.idle_duty;
                    do_drive    = 1'b1;
                    nxt.elapsed = '0;
                    nxt.run     = ST_IDLE;
                end
                else if (pre.mode == ST_RUN)
                begin
                    nxt.mode = ST_OFF;
                end
            end
            ST_IDLE:
            begin
                if (pre.mode == ST_OFF)
                begin
                    pct      = cfg.off_duty;
                    do_drive = 1'b1;
                    nxt.run  = ST_OFF;
                end
                else if (pre.mode == ST_IDLE)
                begin
                    pct      = cfg.idle_duty;
                    do_drive = 1'b1;
                end
                else if (pre.mode == ST_RUN
                         && elapsed_ext > HOLD_CMP_W'(cfg.idle_hold))
                begin
                    pct         = cfg.min_duty;
                    do_drive    = 1'b1;
                    nxt.run     = ST_RUN;
                    nxt.elapsed = '0;
                end
            end
            default:
            begin
                if (pre.mode == ST_OFF)
                begin
                    pct      = cfg.off_duty;
                    do_drive = 1'b1;
                    nxt.run  = ST_OFF;
                end
                else if (pre.mode == ST_IDLE)
                begin
                    pct      = cfg.idle_duty;
                    do_drive = 1'b1;
                    nxt.run  = ST_IDLE;
                end
                else if (pre.mode == ST_RUN)
                begin
                    nxt.target = clamped;
                    pct        = clamped;
                    do_drive   = elapsed_ext > HOLD_CMP_W'(cfg.startup_hold);
                end
            end
        endcase
        if (do_drive)
        begin
            nxt.target = pct;
            if (pct <= PCT_LIMIT)
            begin
                nxt.applied = pct;
            end
        end
    end

endmodule

/* sv/motor_startup_sequencer.sv */
// ----------------------------------------------------------------------------
// motor_startup_sequencer
// Off / idle / running drive sequencer producing PWM duty and compare value.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word per command byte, button press
// or timer tick, selected by req_type. Output channel (out_valid / out_stall):
// one result word per input word, showing the block after that word.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, indexes above the register list are ignored. Write only
// while no word is in flight.
// Pipeline: state is updated at accept, and the first stage registers the result
// fields with the duty-period product; the second stage forms the compare value
// from the registered product by a reciprocal multiply.
// Throughput: one word per cycle while out_stall is low.
// Reset: state off, duty 2 %, command line empty, registers at defaults,
// pipeline empty.
// Stall: a stalled result holds; one further word may sit in the first stage,
// after which in_stall rises until the output is taken.
// ----------------------------------------------------------------------------
module motor_startup_sequencer
    import mss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [7:0]          rx_byte,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [1:0]          req_mode,
    output logic [PCT_W-1:0]    target_pct,
    output logic [PCT_W-1:0]    applied_pct,
    output logic [CMP_W-1:0]    pwm_compare,
    output logic [LED_W-1:0]    led_period_ms,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    cfg_t               cfg_reg;
    seq_state_t         st_reg;
    seq_state_t         st_next;

    logic               in_accept;
    logic               adv_out;

    logic               s1_valid_reg;
    logic [1:0]         s1_status_reg;
    logic [1:0]         s1_mode_reg;
    logic [PCT_W-1:0]   s1_target_reg;
    logic [PCT_W-1:0]   s1_applied_reg;
    logic [LED_W-1:0]   s1_led_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [LED_W-1:0]   led_next;
    logic [PROD_W-1:0]  prod_next;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [1:0]         out_mode_reg;
    logic [PCT_W-1:0]   out_target_reg;
    logic [PCT_W-1:0]   out_applied_reg;
    logic [CMP_W-1:0]   out_cmp_reg;
    logic [LED_W-1:0]   out_led_reg;
    logic [RECIP_MUL_W-1:0] quot_full;

    mss_step u_step
    (
        .cur      (st_reg),
        .cfg      (cfg_reg),
        .req_type (req_type),
        .rx_byte  (rx_byte),
        .nxt      (st_next)
    );

    assign cfg_ready = 1'b1;
    assign adv_out   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !adv_out;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        unique case (st_next.run)
            ST_OFF:  led_next = LED_OFF;
            ST_IDLE: led_next = LED_IDLE;
            default: led_next = LED_RUN;
        endcase
    end

    assign prod_next = PROD_W'(st_next.applied) * PROD_W'(cfg_reg.pwm_period);
    assign quot_full = RECIP_MUL_W'(s1_prod_reg) * RECIP_MUL_W'(RECIP_100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OFF_DUTY:     cfg_reg.off_duty     <= cfg_data[PCT_W-1:0];
                CFG_IDLE_DUTY:    cfg_reg.idle_duty    <= cfg_data[PCT_W-1:0];
                CFG_MIN_DUTY:     cfg_reg.min_duty     <= cfg_data[PCT_W-1:0];
                CFG_MAX_DUTY:     cfg_reg.max_duty     <= cfg_data[PCT_W-1:0];
                CFG_IDLE_HOLD:    cfg_reg.idle_hold    <= cfg_data;
                CFG_STARTUP_HOLD: cfg_reg.startup_hold <= cfg_data;
                CFG_PWM_PERIOD:   cfg_reg.pwm_period   <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= STATE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                st_reg <= st_next;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv_out)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_status_reg  <= st_next.run;
            s1_mode_reg    <= st_next.mode;
            s1_target_reg  <= st_next.target;
            s1_applied_reg <= st_next.applied;
            s1_led_reg     <= led_next;
            s1_prod_reg    <= prod_next;
        end
        if (adv_out && s1_valid_reg)
        begin
            out_status_reg  <= s1_status_reg;
            out_mode_reg    <= s1_mode_reg;
            out_target_reg  <= s1_target_reg;
            out_applied_reg <= s1_applied_reg;
            out_led_reg     <= s1_led_reg;
            out_cmp_reg     <= quot_full[DIV_SHIFT +: CMP_W];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign req_mode      = out_mode_reg;
    assign target_pct    = out_target_reg;
    assign applied_pct   = out_applied_reg;
    assign pwm_compare   = out_cmp_reg;
    assign led_period_ms = out_led_reg;

    a_applied_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.applied <= PCT_LIMIT)
        else $error("applied duty above limit");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !s1_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after delivery");

    a_elapsed_step: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.elapsed != $past(st_reg.elapsed))
        |-> (st_reg.elapsed == '0
             || st_reg.elapsed == $past(st_reg.elapsed) + TICK_COUNT_WIDTH'(1)))
        else $error("elapsed count jumped");

endmodule

/* tb/sv/motor_startup_sequencer_checker.sv */
// ----------------------------------------------------------------------------
// motor_startup_sequencer_checker
// Watches the input, result and register channels of the sequencer, keeps its
// own model of the drive state and checks every result word, field by field,
// against the oldest predicted word.
// ----------------------------------------------------------------------------
module motor_startup_sequencer_checker
    import mss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [1:0]       req_type,
    input  logic [7:0]       rx_byte,

    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [1:0]       status,
    input  logic [1:0]       req_mode,
    input  logic [PCT_W-1:0] target_pct,
    input  logic [PCT_W-1:0] applied_pct,
    input  logic [CMP_W-1:0] pwm_compare,
    input  logic [LED_W-1:0] led_period_ms,

    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,

    output int               mismatch_count,
    output int               results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        run_state_t       run;
        run_state_t       mode;
        logic [PCT_W-1:0] target;
        logic [PCT_W-1:0] applied;
        logic [CMP_W-1:0] cmp;
        logic [LED_W-1:0] led;
    } drive_word_t;

    drive_word_t                 expected_words[$];
    cfg_t                        regs;
    run_state_t                  run_st;
    run_state_t                  mode_req;
    logic [PCT_W-1:0]            target_duty;
    logic [PCT_W-1:0]            applied_duty;
    logic [TICK_COUNT_WIDTH-1:0] elapsed;
    int unsigned                 line_pos;
    logic [7:0]                  line_buf [3];

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c < CH_COLON;
    endfunction

    // target always follows; the PWM only takes a valid percentage
    function automatic void set_duty(logic [PCT_W-1:0] pct);
        target_duty = pct;
        if (pct <= PCT_LIMIT)
            applied_duty = pct;
    endfunction

    function automatic drive_word_t predict_drive_word(logic [1:0] req, logic [7:0] b);
        drive_word_t      w;
        int unsigned      p;
        int unsigned      value;
        bit               parsed;
        logic [PCT_W-1:0] t;
        logic [63:0]      prod;
        case (req)
            REQ_BYTE:
            begin
                p = line_pos;
                if (p >= 1 && p <= 3)
                    line_buf[p - 1] = b;
                if (b == CH_CR)
                begin
                    parsed = 1'b0;
                    if (p == 3 && is_digit(line_buf[1]))
                    begin
                        value  = line_buf[1] - CH_ZERO;
                        parsed = 1'b1;
                    end
                    else if (p == 4 && is_digit(line_buf[1]) && is_digit(line_buf[2]))
                    begin
                        value  = (line_buf[1] - CH_ZERO) * 10 + (line_buf[2] - CH_ZERO);
                        parsed = 1'b1;
                    end
                    if (parsed && (line_buf[0] == CH_M_UP || line_buf[0] == CH_M_LO))
                    begin
                        if (value <= 2)
                            mode_req = run_state_t'(value[1:0]);
                    end
                    else if (parsed && (line_buf[0] == CH_S_UP || line_buf[0] == CH_S_LO))
                    begin
                        if (value >= SPEED_LO && value <= SPEED_HI)
                            target_duty = PCT_W'(value);
                    end
                    line_buf = '{default: '0};
                    p = 0;
                end
                if (p >= LINE_BUFFER - 1)
                    p = 0;
                line_pos = p + 1;
            end
            REQ_BUTTON: mode_req = (run_st == ST_OFF) ? ST_IDLE : ST_OFF;
            REQ_TICK:
            begin
                if (elapsed != '1)
                    elapsed = elapsed + 1'b1;
            end
            default: ;
        endcase

        case (run_st)
            ST_OFF:
            begin
                if (mode_req == ST_IDLE)
                begin
                    set_duty(regs.idle_duty);
                    elapsed = '0;
                    run_st  = ST_IDLE;
                end
                else if (mode_req == ST_RUN)
                    mode_req = ST_OFF;
            end
            ST_IDLE:
            begin
                if (mode_req == ST_OFF)
                begin
                    set_duty(regs.off_duty);
                    run_st = ST_OFF;
                end
                else if (mode_req == ST_IDLE)
                    set_duty(regs.idle_duty);
                else if (mode_req == ST_RUN && elapsed > regs.idle_hold)
                begin
                    set_duty(regs.min_duty);
                    run_st  = ST_RUN;
                    elapsed = '0;
                end
            end
            default:
            begin
                if (mode_req == ST_OFF)
                begin
                    set_duty(regs.off_duty);
                    run_st = ST_OFF;
                end
                else if (mode_req == ST_IDLE)
                begin
                    set_duty(regs.idle_duty);
                    run_st = ST_IDLE;
                end
                else if (mode_req == ST_RUN)
                begin
                    t = target_duty;
                    if (t < regs.min_duty)
                        t = regs.min_duty;
                    if (t > regs.max_duty)
                        t = regs.max_duty;
                    target_duty = t;
                    if (elapsed > regs.startup_hold)
                        set_duty(t);
                end
            end
        endcase

        prod      = 64'(applied_duty) * 64'(regs.pwm_period);
        w.run     = run_st;
        w.mode    = mode_req;
        w.target  = target_duty;
        w.applied = applied_duty;
        w.cmp     = CMP_W'(prod / 64'd100);
        w.led     = (run_st == ST_OFF) ? LED_OFF : (run_st == ST_IDLE) ? LED_IDLE : LED_RUN;
        return w;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t ns: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        drive_word_t want;
        if (!rst_n)
        begin
            regs         = CFG_RESET;
            run_st       = ST_OFF;
            mode_req     = ST_OFF;
            target_duty  = CFG_RESET.off_duty;
            applied_duty = CFG_RESET.off_duty;
            elapsed      = '0;
            line_pos     = 1;
            line_buf     = '{default: '0};
            expected_words.delete();
            results_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OFF_DUTY:     regs.off_duty     = cfg_data[PCT_W-1:0];
                    CFG_IDLE_DUTY:    regs.idle_duty    = cfg_data[PCT_W-1:0];
                    CFG_MIN_DUTY:     regs.min_duty     = cfg_data[PCT_W-1:0];
                    CFG_MAX_DUTY:     regs.max_duty     = cfg_data[PCT_W-1:0];
                    CFG_IDLE_HOLD:    regs.idle_hold    = cfg_data;
                    CFG_STARTUP_HOLD: regs.startup_hold = cfg_data;
                    CFG_PWM_PERIOD:   regs.pwm_period   = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_words.push_back(predict_drive_word(req_type, rx_byte));
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = expected_words.pop_front();
                    check_field("status", 32'(status), 32'(want.run));
                    check_field("req_mode", 32'(req_mode), 32'(want.mode));
                    check_field("target_pct", 32'(target_pct), 32'(want.target));
                    check_field("applied_pct", 32'(applied_pct), 32'(want.applied));
                    check_field("pwm_compare", 32'(pwm_compare), 32'(want.cmp));
                    check_field("led_period_ms", 32'(led_period_ms), 32'(want.led));
                end
            end
            results_pending <= expected_words.size();
        end
    end

endmodule

/* tb/sv/motor_startup_sequencer_test.sv */
// ----------------------------------------------------------------------------
// motor_startup_sequencer_test
// Drives command bytes, button presses and ticks into the sequencer under
// several register settings and idling mixes; the checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module motor_startup_sequencer_test
    import mss_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED       = 2'd3;
    localparam logic [2:0] CFG_UNUSED       = 3'd7;
    localparam int         LONG_HOLD_CYCLES = 300;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [1:0]       req_type  = REQ_BYTE;
    logic [7:0]       rx_byte   = 8'h00;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [2:0]       cfg_index = CFG_OFF_DUTY;
    logic [15:0]      cfg_data  = 16'h0000;

    logic             in_stall;
    logic             out_valid;
    logic [1:0]       status;
    logic [1:0]       req_mode;
    logic [PCT_W-1:0] target_pct;
    logic [PCT_W-1:0] applied_pct;
    logic [CMP_W-1:0] pwm_compare;
    logic [LED_W-1:0] led_period_ms;
    logic             cfg_ready;

    int mismatch_count;
    int results_pending;
    int sender_idle_pct;
    int stall_pct;
    int hold_len;
    int hold_count;
    int words_sent;

    motor_startup_sequencer dut (.*);

    motor_startup_sequencer_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or one long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_len != 0)
        begin
            out_stall <= 1'b1;
            hold_count++;
            if (hold_count >= hold_len)
            begin
                hold_count = 0;
                hold_len   = 0;
            end
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_word(logic [1:0] req, logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_command(string text);
        for (int i = 0; i < text.len(); i++)
            send_word(REQ_BYTE, text[i]);
        send_word(REQ_BYTE, CH_CR);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // streams all registers plus one write to the unused index
    task automatic load_registers(logic [15:0] off_d, logic [15:0] idle_d,
                                  logic [15:0] min_d, logic [15:0] max_d,
                                  logic [15:0] idle_h, logic [15:0] start_h,
                                  logic [15:0] period);
        logic [2:0]  idx [8];
        logic [15:0] val [8];
        idx = '{CFG_OFF_DUTY, CFG_IDLE_DUTY, CFG_MIN_DUTY, CFG_MAX_DUTY,
                CFG_IDLE_HOLD, CFG_STARTUP_HOLD, CFG_PWM_PERIOD, CFG_UNUSED};
        val = '{off_d, idle_d, min_d, max_d, idle_h, start_h, period, 16'($urandom)};
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_burst();
        int          kind;
        int          digits;
        string       text;
        byte unsigned ch;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            case ($urandom_range(6))
                0, 1:    ch = CH_M_UP;
                2:       ch = CH_M_LO;
                3, 4:    ch = CH_S_UP;
                5:       ch = CH_S_LO;
                default: ch = 8'($urandom);
            endcase
            text   = $sformatf("%c", ch);
            digits = ($urandom_range(7) == 0) ? $urandom_range(3) : 1 + $urandom_range(1);
            repeat (digits)
            begin
                if ($urandom_range(15) == 0)
                    ch = 8'($urandom);
                else
                    ch = CH_ZERO + 8'($urandom_range(9));
                text = $sformatf("%s%c", text, ch);
            end
            send_command(text);
        end
        else if (kind < 42)
            send_command($sformatf("M%0d", $urandom_range(2)));
        else if (kind < 50)
            send_command($sformatf("S%0d", $urandom_range(30, 99)));
        else if (kind < 72)
            repeat ($urandom_range(1, 6)) send_word(REQ_TICK, 8'($urandom));
        else if (kind < 79)
            send_word(REQ_BUTTON, 8'($urandom));
        else if (kind < 91)
            send_word(REQ_BYTE, 8'($urandom));
        else if (kind < 98)
            send_word(REQ_UNUSED, 8'($urandom));
        else
            // overlong line, no carriage return: position can wrap
            repeat ($urandom_range(60, 70)) send_word(REQ_BYTE, 8'($urandom_range(14, 255)));
    endtask

    task automatic run_phase(int idle_pct, int stall_level, int count, bit long_hold);
        int stop;
        sender_idle_pct = idle_pct;
        stall_pct       = stall_level;
        stop            = words_sent + count;
        while (words_sent < stop)
        begin
            if (long_hold && words_sent >= stop - count / 2)
            begin
                hold_len  = LONG_HOLD_CYCLES;
                long_hold = 1'b0;
            end
            send_random_burst();
        end
        wait_for_results();
    endtask

    initial
    begin
        #(5_000_000);
        $display("motor_startup_sequencer_test NOT OK");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        send_word(REQ_BUTTON, 8'h00);
        repeat (6) send_word(REQ_TICK, 8'hFF);
        send_command("m2");
        send_command("S99");
        send_word(REQ_UNUSED, 8'hFF);
        send_command("M7");
        send_command("s25");
        send_word(REQ_BUTTON, 8'h00);
        send_word(REQ_BYTE, 8'h00);
        send_word(REQ_BYTE, CH_CR);
        wait_for_results();

        load_registers(16'd2, 16'd28, 16'd32, 16'd95, 16'd3, 16'd4, 16'd40000);
        run_phase(0, 0, 500, 1'b1);

        // min above max, zero holds, widest period
        load_registers(16'd0, 16'd100, 16'd100, 16'd0, 16'd0, 16'd0, 16'd65535);
        run_phase(78, 0, 400, 1'b0);

        // off and idle duty registers above one hundred, narrowest period
        load_registers(16'd127, 16'd101, 16'd0, 16'd100, 16'd1, 16'd2, 16'd1);
        run_phase(0, 78, 400, 1'b0);

        load_registers({9'($urandom), 7'($urandom_range(100))},
                       {9'($urandom), 7'($urandom_range(100))},
                       16'($urandom_range(20, 50)), 16'($urandom_range(60, 100)),
                       16'($urandom_range(8)), 16'($urandom_range(8)),
                       16'($urandom_range(1, 65535)));
        run_phase(9, 9, 500, 1'b0);

        load_registers(16'($urandom_range(100)), 16'($urandom_range(100)),
                       16'($urandom_range(20, 50)), 16'($urandom_range(60, 100)),
                       16'($urandom_range(8)), 16'($urandom_range(8)),
                       16'($urandom_range(1, 65535)));
        run_phase(0, 0, 200, 1'b0);

        if (mismatch_count == 0)
            $display("motor_startup_sequencer_test OK");
        else
            $display("motor_startup_sequencer_test NOT OK");
        $finish;
    end

endmodule
